### rtl/command_frame_receiver_unit_assert.svh
// Assertion shorthands for the command frame receiver.
// Both forms sample on clk_i and are off while rst_ni is low.
`ifndef COMMAND_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define COMMAND_FRAME_RECEIVER_UNIT_ASSERT_SVH

// Same-cycle implication
`define CFRU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cfru: same-cycle check failed");

// Next-cycle implication
`define CFRU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cfru: next-cycle check failed");

`endif

### rtl/cfru_pkg.sv
`timescale 1ns / 1ps

package cfru_pkg;

  // Command table size
  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  // Field widths
  localparam int BYTE_W  = 8;
  localparam int ENTRY_W = 4;
  localparam int CMP_W   = (IDX_W > ENTRY_W) ? IDX_W : ENTRY_W;

  // Stream data widths (rounded up to whole bytes)
  localparam int S_FIELDS_W = BYTE_W + ENTRY_W + 1 + 3 * BYTE_W;
  localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int M_FIELDS_W = 4 * BYTE_W + ENTRY_W;
  localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

  // Request walking down the cell row
  typedef struct packed {
    logic               valid;
    logic               is_write;
    logic [BYTE_W-1:0]  data;      // received byte
    logic [ENTRY_W-1:0] wr_idx;
    logic               wr_valid;
    logic [BYTE_W-1:0]  wr_id;
    logic [BYTE_W-1:0]  wr_req;
    logic [BYTE_W-1:0]  wr_resp;
    logic [ENTRY_W-1:0] entry;     // entry of the frame in progress
    logic [IDX_W-1:0]   pos;       // index of the cell it enters next
    logic               hit;
    logic [IDX_W-1:0]   hit_idx;
    logic [BYTE_W-1:0]  req;
    logic [BYTE_W-1:0]  resp;
  } tok_t;

endpackage

### rtl/cfru_cell.sv
`timescale 1ns / 1ps

// One command table entry. Applies a passing write, takes part in the
// lowest-index-first id search and hands out the response length of the
// frame's entry.
module cfru_cell
  import cfru_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  tok_t tok_i,
  output tok_t tok_o
);

  logic              valid_q;
  logic [BYTE_W-1:0] id_q;
  logic [BYTE_W-1:0] req_q;
  logic [BYTE_W-1:0] resp_q;
  tok_t              tok_q;
  tok_t              tok_d;
  logic              wr_sel;
  logic              rd_sel;
  logic              match;

  // Decode against this cell's position
  assign wr_sel = tok_i.valid && tok_i.is_write &&
                  (CMP_W'(tok_i.wr_idx) == CMP_W'(tok_i.pos));
  assign rd_sel = tok_i.valid && (CMP_W'(tok_i.entry) == CMP_W'(tok_i.pos));
  assign match  = tok_i.valid && !tok_i.is_write && !tok_i.hit &&
                  valid_q && (id_q == tok_i.data);

  // Update the request for the next cell
  always_comb begin
    tok_d     = tok_i;
    tok_d.pos = tok_i.pos + IDX_W'(1);
    if (match) begin
      tok_d.hit     = 1'b1;
      tok_d.hit_idx = tok_i.pos;
      tok_d.req     = req_q;
    end
    if (rd_sel) begin
      tok_d.resp = resp_q;
    end
  end

  // Valid bit and hand-off register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      tok_q <= tok_d;
      if (wr_sel) begin
        valid_q <= tok_i.wr_valid;
      end
    end
  end

  // Entry contents
  always_ff @(posedge clk_i) begin
    if (wr_sel) begin
      id_q   <= tok_i.wr_id;
      req_q  <= tok_i.wr_req;
      resp_q <= tok_i.wr_resp;
    end
  end

  assign tok_o = tok_q;

endmodule

### rtl/command_frame_receiver_unit.sv
`timescale 1ns / 1ps

// Command frame receiver: takes link bytes and table writes on the slave stream and
// gives one result per request on the master stream. Frames are start byte, command
// id, request payload, end byte; the id is looked up in a table of TABLE_ENTRIES
// entries, one per cell in a row of cells that each request walks from entry 0 up,
// one cell per cycle. One request is in work at a time; after the row it waits in a
// landing slot and then in the output register, and the next request is taken while a
// result still waits on the master side. The user must write start and end byte values
// on the cfg port only while the block is idle; the block itself does not enforce it.
`include "command_frame_receiver_unit_assert.svh"

module command_frame_receiver_unit
  import cfru_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration writes
  input  logic                 cfg_we_i,
  input  logic                 cfg_addr_i,
  input  logic [BYTE_W-1:0]    cfg_wdata_i,
  // Slave stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [7:0] rx_byte, [11:8] entry_index, [12] entry_valid, [20:13] entry_id,
  // [28:21] entry_request_length, [36:29] entry_response_length
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  input  logic                 s_axis_tuser,   // [0] command
  // Master stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [7:0] payload_byte, [15:8] payload_index, [23:16] frame_command_id,
  // [27:24] matched_entry, [35:28] response_length
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  output logic [2:0]           m_axis_tuser,   // [2:0] event_res
  output logic                 m_axis_tlast    // last_payload
);

  typedef enum logic [1:0] {
    PH_WAIT,
    PH_CMD,
    PH_DATA,
    PH_END
  } phase_e;

  typedef enum logic [2:0] {
    EV_NONE,
    EV_START,
    EV_ACCEPT,
    EV_UNKNOWN,
    EV_PAYLOAD,
    EV_DONE,
    EV_BADEND,
    EV_WRITTEN
  } ev_e;

  localparam logic CFG_START = 1'b0;
  localparam logic CFG_END   = 1'b1;

  logic [BYTE_W-1:0]  start_q;
  logic [BYTE_W-1:0]  end_q;
  phase_e             phase_q;
  phase_e             phase_d;
  logic [ENTRY_W-1:0] cur_entry_q;
  logic [ENTRY_W-1:0] cur_entry_d;
  logic [BYTE_W-1:0]  cur_id_q;
  logic [BYTE_W-1:0]  cur_id_d;
  logic [BYTE_W-1:0]  taken_q;
  logic [BYTE_W-1:0]  taken_d;
  logic [BYTE_W-1:0]  expected_q;
  logic [BYTE_W-1:0]  expected_d;
  logic               busy_q;
  tok_t               land_q;

  logic               out_valid_q;
  ev_e                out_ev_q;
  logic [BYTE_W-1:0]  out_byte_q;
  logic [BYTE_W-1:0]  out_index_q;
  logic [BYTE_W-1:0]  out_id_q;
  logic [ENTRY_W-1:0] out_entry_q;
  logic [BYTE_W-1:0]  out_resp_q;
  logic               out_last_q;

  ev_e                res_ev;
  logic [BYTE_W-1:0]  res_byte;
  logic [BYTE_W-1:0]  res_index;
  logic [BYTE_W-1:0]  res_id;
  logic [ENTRY_W-1:0] res_entry;
  logic [BYTE_W-1:0]  res_resp;
  logic               res_last;
  logic [BYTE_W-1:0]  taken_inc;

  logic                     accept;
  logic                     commit;
  tok_t                     chain_tok [TABLE_ENTRIES:0];
  logic [TABLE_ENTRIES-1:0] chain_vld;

  assign s_axis_tready = !busy_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign commit        = land_q.valid && (!out_valid_q || m_axis_tready);

  // Request entering the cell row
  always_comb begin
    chain_tok[0]          = '0;
    chain_tok[0].valid    = accept;
    chain_tok[0].is_write = s_axis_tuser;
    chain_tok[0].data     = s_axis_tdata[7:0];
    chain_tok[0].wr_idx   = s_axis_tdata[11:8];
    chain_tok[0].wr_valid = s_axis_tdata[12];
    chain_tok[0].wr_id    = s_axis_tdata[20:13];
    chain_tok[0].wr_req   = s_axis_tdata[28:21];
    chain_tok[0].wr_resp  = s_axis_tdata[36:29];
    chain_tok[0].entry    = cur_entry_q;
  end

  // Row of table cells
  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    cfru_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (chain_tok[g]),
      .tok_o  (chain_tok[g+1])
    );
    assign chain_vld[g] = chain_tok[g+1].valid;
  end

  // Result and next frame state from the request that left the row
  always_comb begin
    phase_d     = phase_q;
    cur_entry_d = cur_entry_q;
    cur_id_d    = cur_id_q;
    taken_d     = taken_q;
    expected_d  = expected_q;
    res_ev      = EV_NONE;
    res_byte    = '0;
    res_index   = '0;
    res_id      = '0;
    res_entry   = '0;
    res_resp    = '0;
    res_last    = 1'b0;
    taken_inc   = taken_q + BYTE_W'(1);
    if (land_q.is_write) begin
      if (32'(land_q.wr_idx) < TABLE_ENTRIES) begin
        res_ev    = EV_WRITTEN;
        res_entry = land_q.wr_idx;
      end
    end else begin
      case (phase_q)
        PH_WAIT: begin
          if (land_q.data == start_q) begin
            phase_d = PH_CMD;
            res_ev  = EV_START;
          end
        end
        PH_CMD: begin
          if (land_q.hit) begin
            cur_entry_d = ENTRY_W'(land_q.hit_idx);
            cur_id_d    = land_q.data;
            taken_d     = '0;
            expected_d  = land_q.req;
            phase_d     = (land_q.req == '0) ? PH_END : PH_DATA;
            res_ev      = EV_ACCEPT;
            res_id      = land_q.data;
            res_entry   = ENTRY_W'(land_q.hit_idx);
          end else begin
            phase_d = PH_WAIT;
            res_ev  = EV_UNKNOWN;
            res_id  = land_q.data;
          end
        end
        PH_DATA: begin
          res_ev    = EV_PAYLOAD;
          res_byte  = land_q.data;
          res_index = taken_q;
          res_id    = cur_id_q;
          res_entry = cur_entry_q;
          taken_d   = taken_inc;
          if (taken_inc == expected_q) begin
            res_last = 1'b1;
            phase_d  = PH_END;
          end
        end
        PH_END: begin
          res_id    = cur_id_q;
          res_entry = cur_entry_q;
          if (land_q.data == end_q) begin
            res_ev   = EV_DONE;
            res_resp = land_q.resp;
          end else begin
            res_ev = EV_BADEND;
          end
          phase_d = PH_WAIT;
        end
        default: begin
          phase_d = PH_WAIT;
        end
      endcase
    end
  end

  // Frame state, landing slot and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q     <= '0;
      end_q       <= '0;
      phase_q     <= PH_WAIT;
      cur_entry_q <= '0;
      cur_id_q    <= '0;
      taken_q     <= '0;
      expected_q  <= '0;
      busy_q      <= 1'b0;
      land_q      <= '0;
      out_valid_q <= 1'b0;
      out_ev_q    <= EV_NONE;
      out_byte_q  <= '0;
      out_index_q <= '0;
      out_id_q    <= '0;
      out_entry_q <= '0;
      out_resp_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_START: start_q <= cfg_wdata_i;
          CFG_END:   end_q   <= cfg_wdata_i;
          default:   ;
        endcase
      end
      if (accept) begin
        busy_q <= 1'b1;
      end
      if (chain_tok[TABLE_ENTRIES].valid) begin
        land_q <= chain_tok[TABLE_ENTRIES];
      end else if (commit) begin
        land_q.valid <= 1'b0;
      end
      if (commit) begin
        phase_q     <= phase_d;
        cur_entry_q <= cur_entry_d;
        cur_id_q    <= cur_id_d;
        taken_q     <= taken_d;
        expected_q  <= expected_d;
        busy_q      <= 1'b0;
        out_valid_q <= 1'b1;
        out_ev_q    <= res_ev;
        out_byte_q  <= res_byte;
        out_index_q <= res_index;
        out_id_q    <= res_id;
        out_entry_q <= res_entry;
        out_resp_q  <= res_resp;
        out_last_q  <= res_last;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_ev_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {(M_TDATA_W - M_FIELDS_W)'(0), out_resp_q, out_entry_q,
                          out_id_q, out_index_q, out_byte_q};

  // A request leaving the row always belongs to the open item
  `CFRU_ASSERT_IMP(a_exit_busy, chain_tok[TABLE_ENTRIES].valid, busy_q && !land_q.valid)
  // Never more than one request in work
  `CFRU_ASSERT_IMP(a_one_req, 1'b1, $countones({land_q.valid, chain_vld}) <= 1)
  // Payload bytes keep the frame in its payload or end phase
  `CFRU_ASSERT_NXT(a_payload_phase, commit && res_ev == EV_PAYLOAD, phase_q == PH_DATA || phase_q == PH_END)
  // Frame close or rejection returns to waiting
  `CFRU_ASSERT_NXT(a_close_wait, commit && (res_ev == EV_DONE || res_ev == EV_BADEND || res_ev == EV_UNKNOWN), phase_q == PH_WAIT)
  // Last-byte flag only rides on payload results
  `CFRU_ASSERT_IMP(a_last_payload, m_axis_tvalid && m_axis_tlast, m_axis_tuser == EV_PAYLOAD)

endmodule

### sim/tb_command_frame_receiver_unit.sv
`timescale 1ns / 1ps

module tb_command_frame_receiver_unit;
  import cfru_pkg::*;

  // Register indexes on the cfg port
  localparam logic REG_START_BYTE = 1'b0;
  localparam logic REG_END_BYTE   = 1'b1;

  // Table mirrors: one follows accepted requests, one follows the generator
  localparam int MIRROR_PRED = 0;
  localparam int MIRROR_GEN  = 1;

  localparam int STUCK_LIMIT = 2000;
  localparam int TAIL_CYCLES = 3 * (TABLE_ENTRIES + 2);

  typedef enum logic {
    CMD_RX_BYTE     = 1'b0,
    CMD_TABLE_WRITE = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    EVT_NONE          = 3'd0,
    EVT_START         = 3'd1,
    EVT_CMD_ACCEPTED  = 3'd2,
    EVT_CMD_UNKNOWN   = 3'd3,
    EVT_PAYLOAD       = 3'd4,
    EVT_FRAME_DONE    = 3'd5,
    EVT_BAD_END       = 3'd6,
    EVT_TABLE_WRITTEN = 3'd7
  } evt_e;

  typedef enum logic [1:0] {
    PH_WAIT_START,
    PH_READ_CMD,
    PH_READ_PAYLOAD,
    PH_READ_END
  } rx_phase_e;

  typedef struct packed {
    cmd_e               cmd;
    logic [BYTE_W-1:0]  rx;
    logic [ENTRY_W-1:0] idx;
    logic               valid;
    logic [BYTE_W-1:0]  id;
    logic [BYTE_W-1:0]  req;
    logic [BYTE_W-1:0]  resp;
  } cmd_req_t;

  localparam int REQ_W = $bits(cmd_req_t);

  typedef struct packed {
    evt_e               evt;
    logic [BYTE_W-1:0]  pbyte;
    logic [BYTE_W-1:0]  pidx;
    logic [BYTE_W-1:0]  fid;
    logic [ENTRY_W-1:0] ent;
    logic [BYTE_W-1:0]  resp;
    logic               last;
  } frame_result_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] id;
    logic [BYTE_W-1:0] req;
    logic [BYTE_W-1:0] resp;
  } tbl_entry_t;

  // DUT signals
  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic                 cfg_addr_i = REG_START_BYTE;
  logic [BYTE_W-1:0]    cfg_wdata_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic                 s_axis_tuser = CMD_RX_BYTE;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [2:0]           m_axis_tuser;
  logic                 m_axis_tlast;

  command_frame_receiver_unit i_dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Stimulus and expectation stores
  cmd_req_t      pending_q[$];
  frame_result_t result_q[$];
  cmd_req_t      cur_req;
  int            mismatches = 0;
  int            queued_items = 0;
  int            long_budget = 2;
  int            send_wait = 0;
  int            recv_wait = 0;
  int            stuck_cycles = 0;
  bit            tx_calm = 1'b0;
  bit            rx_calm = 1'b0;
  logic [BYTE_W-1:0] id_pool[8];

  // Deframer state as seen by the predictor
  tbl_entry_t         cmd_table[2][TABLE_ENTRIES];
  logic [BYTE_W-1:0]  cfg_start_q = '0;
  logic [BYTE_W-1:0]  cfg_end_q = '0;
  rx_phase_e          rx_phase = PH_WAIT_START;
  logic [ENTRY_W-1:0] cur_entry = '0;
  logic [BYTE_W-1:0]  cur_id = '0;
  logic [BYTE_W-1:0]  bytes_taken = '0;
  logic [BYTE_W-1:0]  bytes_expected = '0;

  // Lowest valid entry holding this id, or -1
  function automatic int find_entry(int side, logic [BYTE_W-1:0] id);
    find_entry = -1;
    for (int k = TABLE_ENTRIES - 1; k >= 0; k--) begin
      if (cmd_table[side][k].valid && cmd_table[side][k].id == id) find_entry = k;
    end
  endfunction

  // Advances the deframer by one request and returns its result
  function automatic frame_result_t deframe_step(cmd_req_t it);
    frame_result_t r;
    int            hit;
    r = '0;
    if (it.cmd == CMD_TABLE_WRITE) begin
      cmd_table[MIRROR_PRED][it.idx] = {it.valid, it.id, it.req, it.resp};
      r.evt = EVT_TABLE_WRITTEN;
      r.ent = it.idx;
    end else begin
      case (rx_phase)
        PH_WAIT_START: begin
          if (it.rx == cfg_start_q) begin
            rx_phase = PH_READ_CMD;
            r.evt    = EVT_START;
          end
        end
        PH_READ_CMD: begin
          hit = find_entry(MIRROR_PRED, it.rx);
          if (hit >= 0) begin
            cur_entry      = ENTRY_W'(hit);
            cur_id         = it.rx;
            bytes_taken    = '0;
            bytes_expected = cmd_table[MIRROR_PRED][hit].req;
            // zero-length request skips straight to the end byte
            rx_phase = (bytes_expected == 0) ? PH_READ_END : PH_READ_PAYLOAD;
            r.evt    = EVT_CMD_ACCEPTED;
            r.fid    = cur_id;
            r.ent    = cur_entry;
          end else begin
            rx_phase = PH_WAIT_START;
            r.evt    = EVT_CMD_UNKNOWN;
            r.fid    = it.rx;
          end
        end
        PH_READ_PAYLOAD: begin
          r.evt   = EVT_PAYLOAD;
          r.pbyte = it.rx;
          r.pidx  = bytes_taken;
          r.fid   = cur_id;
          r.ent   = cur_entry;
          bytes_taken = bytes_taken + BYTE_W'(1);
          if (bytes_taken == bytes_expected) begin
            r.last   = 1'b1;
            rx_phase = PH_READ_END;
          end
        end
        default: begin
          r.fid = cur_id;
          r.ent = cur_entry;
          if (it.rx == cfg_end_q) begin
            // response length comes from the table as it is now
            r.evt  = EVT_FRAME_DONE;
            r.resp = cmd_table[MIRROR_PRED][cur_entry].resp;
          end else begin
            r.evt = EVT_BAD_END;
          end
          rx_phase = PH_WAIT_START;
        end
      endcase
    end
    return r;
  endfunction

  function automatic int draw_wait(bit calm);
    return calm ? 0 : $urandom_range(0, 19);
  endfunction

  task automatic flag_error(string msg);
    mismatches++;
    if (mismatches <= 50) $display("%0t ERROR %s", $realtime, msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) flag_error($sformatf("%s: got 0x%0h, want 0x%0h", name, got, want));
  endtask

  // Request driver
  always @(posedge clk_i or negedge rst_ni) begin
    bit next_valid;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= CMD_RX_BYTE;
      send_wait     = 0;
    end else begin
      next_valid = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        result_q.push_back(deframe_step(cur_req));
        next_valid = 1'b0;
        send_wait  = draw_wait(tx_calm);
      end
      if (!next_valid) begin
        if (send_wait > 0) begin
          send_wait--;
        end else if (pending_q.size() != 0) begin
          cur_req      = pending_q.pop_front();
          s_axis_tdata <= S_TDATA_W'({cur_req.resp, cur_req.req, cur_req.id,
                                      cur_req.valid, cur_req.idx, cur_req.rx});
          s_axis_tuser <= cur_req.cmd;
          next_valid   = 1'b1;
        end
      end
      s_axis_tvalid <= next_valid;
    end
  end

  // Result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    frame_result_t want;
    bit            next_ready;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_wait     = 0;
    end else begin
      next_ready = m_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        if (result_q.size() == 0) begin
          flag_error("result with no request waiting");
        end else begin
          want = result_q.pop_front();
          check_field("event_res", 32'(m_axis_tuser), 32'(want.evt));
          check_field("payload_byte", 32'(m_axis_tdata[7:0]), 32'(want.pbyte));
          check_field("payload_index", 32'(m_axis_tdata[15:8]), 32'(want.pidx));
          check_field("frame_command_id", 32'(m_axis_tdata[23:16]), 32'(want.fid));
          check_field("matched_entry", 32'(m_axis_tdata[27:24]), 32'(want.ent));
          check_field("response_length", 32'(m_axis_tdata[35:28]), 32'(want.resp));
          check_field("last_payload", 32'(m_axis_tlast), 32'(want.last));
        end
        next_ready = 1'b0;
        recv_wait  = draw_wait(rx_calm);
      end
      if (!next_ready) begin
        if (recv_wait > 0) recv_wait--;
        else next_ready = 1'b1;
      end
      m_axis_tready <= next_ready;
    end
  end

  // Watchdog on handshake progress
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stuck_cycles <= 0;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles == STUCK_LIMIT) begin
          $display("command_frame_receiver_unit: mismatch");
          $finish;
        end
      end
    end
  end

  // Stimulus helpers
  task automatic queue_byte(logic [BYTE_W-1:0] b);
    cmd_req_t it;
    it       = cmd_req_t'(REQ_W'({$urandom, $urandom}));
    it.cmd   = CMD_RX_BYTE;
    it.rx    = b;
    pending_q.push_back(it);
    queued_items++;
  endtask

  task automatic queue_write(logic [ENTRY_W-1:0] idx, logic valid, logic [BYTE_W-1:0] id,
                             logic [BYTE_W-1:0] req, logic [BYTE_W-1:0] resp);
    cmd_req_t it;
    it.cmd   = CMD_TABLE_WRITE;
    it.rx    = BYTE_W'($urandom);
    it.idx   = idx;
    it.valid = valid;
    it.id    = id;
    it.req   = req;
    it.resp  = resp;
    cmd_table[MIRROR_GEN][idx] = {valid, id, req, resp};
    pending_q.push_back(it);
    queued_items++;
  endtask

  // Mostly ids from a small pool, so duplicates and misses both occur
  function automatic logic [BYTE_W-1:0] pick_id();
    return ($urandom_range(0, 9) < 7) ? id_pool[$urandom_range(0, 7)] : BYTE_W'($urandom);
  endfunction

  task automatic random_write();
    int                pick;
    logic [BYTE_W-1:0] len;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      len = BYTE_W'($urandom_range(0, 5));
    end else if (pick < 97 || long_budget == 0) begin
      len = BYTE_W'($urandom_range(6, 24));
    end else begin
      len = BYTE_W'($urandom_range(200, 255));
      long_budget--;
    end
    queue_write(ENTRY_W'($urandom_range(0, TABLE_ENTRIES - 1)), $urandom_range(0, 4) != 0,
                pick_id(), len, BYTE_W'($urandom));
  endtask

  // Well-formed frame for an id the table currently knows
  task automatic good_frame();
    int                k;
    int                n;
    int                hit;
    int                len;
    logic [BYTE_W-1:0] id;
    k = $urandom_range(0, TABLE_ENTRIES - 1);
    n = 0;
    while (!cmd_table[MIRROR_GEN][k].valid && n < TABLE_ENTRIES) begin
      k = (k + 1) % TABLE_ENTRIES;
      n++;
    end
    if (!cmd_table[MIRROR_GEN][k].valid)
      queue_write(ENTRY_W'(k), 1'b1, pick_id(), BYTE_W'($urandom_range(0, 5)),
                  BYTE_W'($urandom));
    id  = cmd_table[MIRROR_GEN][k].id;
    hit = find_entry(MIRROR_GEN, id);
    len = cmd_table[MIRROR_GEN][hit].req;
    queue_byte(cfg_start_q);
    queue_byte(id);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 29) == 0) random_write();
      queue_byte(BYTE_W'($urandom));
    end
    queue_byte(($urandom_range(0, 9) != 0) ? cfg_end_q : BYTE_W'($urandom));
    // keep long payloads rare
    if (len > 24) queue_write(ENTRY_W'(hit), 1'b1, id, BYTE_W'($urandom_range(0, 5)),
                              BYTE_W'($urandom));
  endtask

  task automatic broken_frame();
    int n;
    queue_byte(cfg_start_q);
    queue_byte(pick_id());
    n = $urandom_range(0, 4);
    for (int i = 0; i < n; i++) queue_byte(BYTE_W'($urandom));
    queue_byte($urandom_range(0, 1) ? cfg_end_q : BYTE_W'($urandom));
  endtask

  task automatic random_phase(int n);
    int target;
    int pick;
    target = queued_items + n;
    while (queued_items < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        random_write();
      end else if (pick < 20) begin
        queue_byte(BYTE_W'($urandom));
        queued_items--;   // stray bytes are mostly ignored, not counted
      end else if (pick < 32) begin
        broken_frame();
      end else begin
        good_frame();
      end
    end
  endtask

  task automatic set_config(logic [BYTE_W-1:0] start_b, logic [BYTE_W-1:0] end_b);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= REG_START_BYTE;
    cfg_wdata_i <= start_b;
    @(posedge clk_i);
    cfg_addr_i  <= REG_END_BYTE;
    cfg_wdata_i <= end_b;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_start_q = start_b;
    cfg_end_q   = end_b;
  endtask

  // Checked between edges, once driver and monitor have settled
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_q.size() != 0 || s_axis_tvalid || result_q.size() != 0);
  endtask

  // Main sequence
  initial begin
    for (int s = 0; s < 2; s++)
      for (int k = 0; k < TABLE_ENTRIES; k++) cmd_table[s][k] = '0;
    foreach (id_pool[i]) id_pool[i] = BYTE_W'($urandom);
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed frames
    set_config(8'hA5, 8'h5A);
    @(negedge clk_i);
    queue_byte(8'h00);                                // not a start byte: ignored
    queue_write(4'd0, 1'b1, 8'h10, 8'd2, 8'hFF);
    queue_write(4'd1, 1'b1, 8'h10, 8'd7, 8'h01);      // same id, entry 0 wins
    queue_write(4'd15, 1'b1, 8'hFF, 8'd0, 8'h80);     // zero-length request
    queue_write(4'd2, 1'b0, 8'h00, 8'd0, 8'h00);      // disabled entry
    queue_byte(8'hA5); queue_byte(8'h10); queue_byte(8'h00); queue_byte(8'hFF);
    queue_byte(8'h5A);
    queue_byte(8'hA5); queue_byte(8'hFF); queue_byte(8'h5A);
    queue_byte(8'hA5); queue_byte(8'h00);             // unknown command
    queue_byte(8'hA5); queue_byte(8'hFF); queue_byte(8'h00);  // bad end byte
    // table rewrite in the middle of a frame
    queue_byte(8'hA5); queue_byte(8'h10); queue_byte(8'h33);
    queue_write(4'd0, 1'b1, 8'h10, 8'd2, 8'h44);
    queue_byte(8'h44); queue_byte(8'h5A);
    wait_drained();

    // Random phases over several start/end settings
    for (int p = 0; p < 5; p++) begin
      case (p)
        0:       set_config(8'h00, 8'hFF);
        1:       set_config(8'hFF, 8'h00);
        2:       set_config(BYTE_W'($urandom), BYTE_W'($urandom));
        3:       set_config(8'h7E, 8'h7E);
        default: set_config(8'h00, 8'h00);
      endcase
      @(negedge clk_i);
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      random_phase(120);
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("command_frame_receiver_unit: match");
    end else begin
      $display("command_frame_receiver_unit: mismatch");
    end
    $finish;
  end

endmodule
